// ===== sv/nfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Notify frame checker package
// Widths, register indexes and verdict codes shared by the interfaces and
// the checker.
// ----------------------------------------------------------------------------
package nfc_pkg;

	localparam int BYTE_W        = 8;
	localparam int CFG_INDEX_W   = 2;
	localparam int CODE_W        = 3;
	localparam int COUNT_W       = 9;

	// The byte count saturates at its all-ones value.
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
	// Two signature bytes, type, length, address and checksum.
	localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 9'd6;

	// Header byte positions within a frame.
	localparam logic [COUNT_W-1:0] POS_SIG_FIRST  = 9'd0;
	localparam logic [COUNT_W-1:0] POS_SIG_SECOND = 9'd1;
	localparam logic [COUNT_W-1:0] POS_TYPE       = 9'd2;
	localparam logic [COUNT_W-1:0] POS_LENGTH     = 9'd3;
	localparam logic [COUNT_W-1:0] POS_ADDRESS    = 9'd4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SIG_FIRST  = 2'd0,
		REG_SIG_SECOND = 2'd1,
		REG_TYPE_CODE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [CODE_W-1:0] {
		ERR_OK        = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_SIGNATURE = 3'd2,
		ERR_TYPE      = 3'd3,
		ERR_LENGTH    = 3'd4,
		ERR_CHECKSUM  = 3'd5
	} err_code_t;

endpackage
`default_nettype wire

// ===== sv/nfc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Notify frame checker channels
// Valid/ready channels for received bytes, verdicts and register writes.
// ----------------------------------------------------------------------------
interface nfc_byte_if;
	logic                       valid;
	logic                       ready;
	logic [nfc_pkg::BYTE_W-1:0] data_byte;
	logic                       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nfc_verdict_if;
	logic                       valid;
	logic                       ready;
	logic                       frame_ok;
	logic [nfc_pkg::CODE_W-1:0] error_code;
	logic [nfc_pkg::BYTE_W-1:0] reg_address;
	logic [nfc_pkg::BYTE_W-1:0] payload_length;

	modport source (output valid, output frame_ok, output error_code,
		output reg_address, output payload_length, input ready);
	modport sink   (input valid, input frame_ok, input error_code,
		input reg_address, input payload_length, output ready);
endinterface

interface nfc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nfc_pkg::CFG_INDEX_W-1:0] index;
	logic [nfc_pkg::BYTE_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/notify_frame_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Notify frame checker
// Checks a received frame byte by byte and gives one verdict per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Request carries
//  -------   ---------  ------------------------------------------------------
//  frame     in         data_byte, last_byte (one frame byte)
//  verdict   out        frame_ok, error_code, reg_address, payload_length
//  cfg       in         index, data (register write, always accepted)
//
// One byte request is accepted every cycle unless a final byte is stalled in
// the input register. A byte is held in the input register, where the frame
// state and the verdict are worked out, and a verdict then sits in the
// output register until it is taken. Only a final byte can stall in the
// input register, and only while an untaken verdict still holds the output
// register; other bytes always move on. Reset clears the configuration
// registers, the frame state and both valid flags.
//
module notify_frame_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	nfc_byte_if.sink              frame,
	nfc_verdict_if.source         verdict,
	nfc_cfg_if.sink               cfg
);

	// Configuration registers.
	logic [nfc_pkg::BYTE_W-1:0]  sig_first_q;
	logic [nfc_pkg::BYTE_W-1:0]  sig_second_q;
	logic [nfc_pkg::BYTE_W-1:0]  type_code_q;

	// Input register.
	logic                        valid_s1;
	logic [nfc_pkg::BYTE_W-1:0]  byte_s1;
	logic                        last_s1;

	// Frame state.
	logic [nfc_pkg::COUNT_W-1:0] byte_count_q;
	logic [nfc_pkg::BYTE_W-1:0]  xor_q;
	logic                        sig_good_q;
	logic                        type_good_q;
	logic [nfc_pkg::BYTE_W-1:0]  length_q;
	logic [nfc_pkg::BYTE_W-1:0]  address_q;

	// Output register.
	logic                        valid_s2;
	logic                        ok_s2;
	logic [nfc_pkg::CODE_W-1:0]  code_s2;
	logic [nfc_pkg::BYTE_W-1:0]  address_s2;
	logic [nfc_pkg::BYTE_W-1:0]  length_s2;

	// Combinational results of the byte in the input register.
	logic                        advance_s1;
	logic                        accept_in;
	logic [nfc_pkg::COUNT_W-1:0] total;
	logic                        sig_good_d;
	logic                        type_good_d;
	logic [nfc_pkg::BYTE_W-1:0]  length_d;
	logic [nfc_pkg::BYTE_W-1:0]  address_d;
	nfc_pkg::err_code_t          code_d;

	// The byte in the input register moves on unless it is a final byte and
	// the output register still holds a verdict that is not being taken.
	assign advance_s1  = valid_s1 && (!last_s1 || !valid_s2 || verdict.ready);
	assign frame.ready = !valid_s1 || advance_s1;
	assign accept_in   = frame.valid && frame.ready;
	assign cfg.ready   = 1'b1;

	// Frame state update for the byte at the current position.
	always_comb begin
		total       = (byte_count_q == nfc_pkg::COUNT_MAX) ? nfc_pkg::COUNT_MAX :
			byte_count_q + 1'b1;
		sig_good_d  = sig_good_q;
		type_good_d = type_good_q;
		length_d    = length_q;
		address_d   = address_q;
		if (byte_count_q == nfc_pkg::POS_SIG_FIRST && byte_s1 != sig_first_q) begin
			sig_good_d = 1'b0;
		end
		if (byte_count_q == nfc_pkg::POS_SIG_SECOND && byte_s1 != sig_second_q) begin
			sig_good_d = 1'b0;
		end
		if (byte_count_q == nfc_pkg::POS_TYPE && byte_s1 != type_code_q) begin
			type_good_d = 1'b0;
		end
		if (byte_count_q == nfc_pkg::POS_LENGTH) begin
			length_d = byte_s1;
		end
		if (byte_count_q == nfc_pkg::POS_ADDRESS) begin
			address_d = byte_s1;
		end
	end

	// Verdict, checks in priority order. The final byte is compared with the
	// XOR of every byte before it.
	always_comb begin
		if (total < nfc_pkg::FRAME_OVERHEAD) begin
			code_d = nfc_pkg::ERR_SHORT;
		end else if (!sig_good_d) begin
			code_d = nfc_pkg::ERR_SIGNATURE;
		end else if (!type_good_d) begin
			code_d = nfc_pkg::ERR_TYPE;
		end else if ({1'b0, length_d} + nfc_pkg::FRAME_OVERHEAD != total) begin
			code_d = nfc_pkg::ERR_LENGTH;
		end else if (byte_s1 != xor_q) begin
			code_d = nfc_pkg::ERR_CHECKSUM;
		end else begin
			code_d = nfc_pkg::ERR_OK;
		end
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_first_q  <= '0;
			sig_second_q <= '0;
			type_code_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				nfc_pkg::REG_SIG_FIRST:  sig_first_q  <= cfg.data;
				nfc_pkg::REG_SIG_SECOND: sig_second_q <= cfg.data;
				nfc_pkg::REG_TYPE_CODE:  type_code_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// Frame state: returns to its reset value after each final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			xor_q        <= '0;
			sig_good_q   <= 1'b1;
			type_good_q  <= 1'b1;
			length_q     <= '0;
			address_q    <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				byte_count_q <= '0;
				xor_q        <= '0;
				sig_good_q   <= 1'b1;
				type_good_q  <= 1'b1;
				length_q     <= '0;
				address_q    <= '0;
			end else begin
				byte_count_q <= total;
				xor_q        <= xor_q ^ byte_s1;
				sig_good_q   <= sig_good_d;
				type_good_q  <= type_good_d;
				length_q     <= length_d;
				address_q    <= address_d;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (verdict.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			ok_s2      <= (code_d == nfc_pkg::ERR_OK);
			code_s2    <= code_d;
			address_s2 <= (code_d == nfc_pkg::ERR_OK) ? address_d : '0;
			length_s2  <= (code_d == nfc_pkg::ERR_OK) ? length_d : '0;
		end
	end

	assign verdict.valid          = valid_s2;
	assign verdict.frame_ok       = ok_s2;
	assign verdict.error_code     = code_s2;
	assign verdict.reg_address    = address_s2;
	assign verdict.payload_length = length_s2;

`ifndef SYNTHESIS
	// A passing verdict always carries the ok code, and a failing one never.
	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (ok_s2 == (code_s2 == nfc_pkg::ERR_OK)))
		else $error("frame_ok disagrees with error_code");

	// A failed frame reports neither address nor length.
	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ok_s2) |-> (address_s2 == '0 && length_s2 == '0))
		else $error("failed verdict carries address or length");

	// The frame state starts afresh after a final byte has been judged.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && last_s1) |=> (byte_count_q == '0 && xor_q == '0))
		else $error("frame state not cleared after final byte");

	// A final byte never overwrites a verdict that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !verdict.ready) |-> !(advance_s1 && last_s1))
		else $error("pending verdict overwritten");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Notify frame checker testbench
// Streams frame bytes into the checker under random valid and ready gaps and
// predicts every verdict from its own model of the frame state. Received
// verdicts are compared field by field, in order. The run moves through
// several register settings and ends with a single pass or fail line.
// ----------------------------------------------------------------------------
module tb;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 10;
	// Lets the pipeline empty, with some margin, before a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// Random bytes over all phases, on top of the directed frames and the
	// two long frames, which together bring the run to about 1950 bytes.
	localparam int RANDOM_BYTES  = 1140;
	localparam int PHASES        = 8;

	typedef logic [nfc_pkg::BYTE_W-1:0] octet_t;

	typedef struct packed {
		octet_t octet;
		logic   is_last;
	} frame_byte_t;

	typedef struct packed {
		logic               frame_ok;
		nfc_pkg::err_code_t code;
		octet_t             address;
		octet_t             length;
	} verdict_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	nfc_byte_if    frame ();
	nfc_verdict_if verdict ();
	nfc_cfg_if     cfg ();

	notify_frame_checker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.verdict (verdict),
		.cfg     (cfg)
	);

	always #HALF_PERIOD clk = ~clk;

	// Our own copy of the checker's registers, updated on each accepted write.
	octet_t sig_first_reg  = '0;
	octet_t sig_second_reg = '0;
	octet_t type_code_reg  = '0;

	// Our own copy of the frame state, advanced on each accepted byte request.
	logic [nfc_pkg::COUNT_W-1:0] rx_count   = '0;
	octet_t                      rx_xor     = '0;
	logic                        sig_match  = 1'b1;
	logic                        type_match = 1'b1;
	octet_t                      rx_length  = '0;
	octet_t                      rx_address = '0;

	verdict_t    expected_verdicts [$];
	frame_byte_t pending_bytes [$];

	int   bytes_queued   = 0;
	int   bytes_accepted = 0;
	int   error_count    = 0;
	int   cycle_count    = 0;
	logic byte_fire      = 1'b0;
	int   send_gap       = 0;
	int   stall_left     = 0;
	bit   idling         = 1'b1;

	// Most gaps are absent or short; now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d",
			cycle_count, what, got, want);
		error_count++;
	endtask

	// Advances the frame state by one byte and, on the final byte, works out
	// the verdict in the checker's priority order and clears the frame state.
	task automatic predict_byte(input octet_t octet, input logic is_last);
		logic [nfc_pkg::COUNT_W-1:0] pos;
		logic [nfc_pkg::COUNT_W-1:0] total;
		octet_t                      prior;
		verdict_t                    v;
		pos   = rx_count;
		prior = rx_xor;
		if (pos == nfc_pkg::POS_SIG_FIRST && octet != sig_first_reg)
			sig_match = 1'b0;
		if (pos == nfc_pkg::POS_SIG_SECOND && octet != sig_second_reg)
			sig_match = 1'b0;
		if (pos == nfc_pkg::POS_TYPE && octet != type_code_reg)
			type_match = 1'b0;
		if (pos == nfc_pkg::POS_LENGTH)
			rx_length = octet;
		if (pos == nfc_pkg::POS_ADDRESS)
			rx_address = octet;
		// The count sticks at its top value on very long frames.
		total    = (pos != nfc_pkg::COUNT_MAX) ? pos + 1'b1 : nfc_pkg::COUNT_MAX;
		rx_count = total;
		rx_xor   = prior ^ octet;
		if (is_last) begin
			if (total < nfc_pkg::FRAME_OVERHEAD)
				v.code = nfc_pkg::ERR_SHORT;
			else if (!sig_match)
				v.code = nfc_pkg::ERR_SIGNATURE;
			else if (!type_match)
				v.code = nfc_pkg::ERR_TYPE;
			else if ({1'b0, rx_length} + nfc_pkg::FRAME_OVERHEAD != total)
				v.code = nfc_pkg::ERR_LENGTH;
			else if (octet != prior)
				v.code = nfc_pkg::ERR_CHECKSUM;
			else
				v.code = nfc_pkg::ERR_OK;
			v.frame_ok = (v.code == nfc_pkg::ERR_OK);
			v.address  = v.frame_ok ? rx_address : '0;
			v.length   = v.frame_ok ? rx_length : '0;
			expected_verdicts.push_back(v);
			rx_count   = '0;
			rx_xor     = '0;
			sig_match  = 1'b1;
			type_match = 1'b1;
			rx_length  = '0;
			rx_address = '0;
		end
	endtask

	// Byte channel, sampled side: each accepted request feeds the predictor.
	// byte_fire tells the driver at the next falling edge that its request went.
	always @(posedge clk) begin
		byte_fire <= arst_n && frame.valid && frame.ready;
		if (arst_n && frame.valid && frame.ready) begin
			predict_byte(frame.data_byte, frame.last_byte);
			bytes_accepted <= bytes_accepted + 1;
		end
	end

	// Byte channel, driven side. A request is held until it is taken; after
	// that a random gap may follow before the next queued byte goes out.
	always @(negedge clk) begin
		frame_byte_t next_byte;
		if (arst_n && (byte_fire || !frame.valid)) begin
			if (send_gap != 0) begin
				frame.valid <= 1'b0;
				send_gap    <= send_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				next_byte        = pending_bytes.pop_front();
				frame.valid     <= 1'b1;
				frame.data_byte <= next_byte.octet;
				frame.last_byte <= next_byte.is_last;
				send_gap        <= idling ? pick_gap() : 0;
			end else begin
				frame.valid <= 1'b0;
			end
		end
	end

	// Verdict channel back-pressure: ready drops for random stretches, which
	// lets a final byte stall behind an untaken verdict.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				verdict.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else begin
				verdict.ready <= 1'b1;
				if (idling && $urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// Each accepted verdict is matched against the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && verdict.valid && verdict.ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict with nothing pending, error_code",
					verdict.error_code, -1);
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict.frame_ok !== want.frame_ok)
					report_mismatch("frame_ok", verdict.frame_ok, want.frame_ok);
				if (verdict.error_code !== want.code)
					report_mismatch("error_code", verdict.error_code, want.code);
				if (verdict.reg_address !== want.address)
					report_mismatch("reg_address", verdict.reg_address, want.address);
				if (verdict.payload_length !== want.length)
					report_mismatch("payload_length", verdict.payload_length,
						want.length);
			end
		end
	end

	// Register writes are mirrored into the predictor as they are accepted.
	always @(posedge clk) begin
		if (arst_n && cfg.valid && cfg.ready) begin
			case (nfc_pkg::cfg_reg_t'(cfg.index))
				nfc_pkg::REG_SIG_FIRST:  sig_first_reg  = cfg.data;
				nfc_pkg::REG_SIG_SECOND: sig_second_reg = cfg.data;
				nfc_pkg::REG_TYPE_CODE:  type_code_reg  = cfg.data;
				default: ;
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[notify_frame_checker] ERROR");
			$finish;
		end
	end

	task automatic push_byte(input octet_t octet, input logic is_last);
		pending_bytes.push_back({octet, is_last});
		bytes_queued++;
	endtask

	// Queues a frame of header, payload and a trailing checksum. A non-zero
	// flip spoils the checksum; the header bytes are taken as given, so a
	// caller can spoil the signature, type or length as it likes.
	task automatic queue_frame(input octet_t sig0, input octet_t sig1,
			input octet_t kind, input octet_t length, input octet_t address,
			input int payload_count, input octet_t check_flip);
		octet_t sum;
		octet_t octet;
		sum = sig0 ^ sig1 ^ kind ^ length ^ address;
		push_byte(sig0, 1'b0);
		push_byte(sig1, 1'b0);
		push_byte(kind, 1'b0);
		push_byte(length, 1'b0);
		push_byte(address, 1'b0);
		for (int i = 0; i < payload_count; i++) begin
			octet = octet_t'($urandom);
			sum ^= octet;
			push_byte(octet, 1'b0);
		end
		push_byte(sum ^ check_flip, 1'b1);
	endtask

	// Random bytes with no structure, often too few for a frame.
	task automatic queue_noise(input int count);
		for (int i = 0; i < count; i++)
			push_byte(octet_t'($urandom), i == count - 1);
	endtask

	// Mostly well-formed frames with random content, so that most verdicts
	// get past the early checks; the rest carry one planted fault or are noise.
	task automatic queue_random_frame();
		int     roll;
		int     payload;
		octet_t f0;
		octet_t f1;
		octet_t f2;
		octet_t length;
		octet_t flip;
		payload = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
			: $urandom_range(0, 8);
		f0     = sig_first_reg;
		f1     = sig_second_reg;
		f2     = type_code_reg;
		length = octet_t'(payload);
		flip   = '0;
		roll   = $urandom_range(0, 99);
		if (roll >= 93) begin
			queue_noise($urandom_range(1, 12));
		end else begin
			if (roll >= 55 && roll < 63)
				f0 ^= octet_t'($urandom_range(1, 255));
			else if (roll >= 63 && roll < 71)
				f1 ^= octet_t'($urandom_range(1, 255));
			else if (roll >= 71 && roll < 79)
				f2 ^= octet_t'($urandom_range(1, 255));
			else if (roll >= 79 && roll < 87)
				length = octet_t'(payload + $urandom_range(1, 255));
			else if (roll >= 87)
				flip = octet_t'($urandom_range(1, 255));
			queue_frame(f0, f1, f2, length, octet_t'($urandom), payload, flip);
		end
	endtask

	task automatic write_reg(input nfc_pkg::cfg_reg_t idx, input octet_t value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic program_checker(input octet_t sig0, input octet_t sig1,
			input octet_t kind);
		write_reg(nfc_pkg::REG_SIG_FIRST, sig0);
		write_reg(nfc_pkg::REG_SIG_SECOND, sig1);
		write_reg(nfc_pkg::REG_TYPE_CODE, kind);
	endtask

	// Waits until every queued byte has been taken and every verdict has
	// arrived, then gives the pipeline time to empty before a register write.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_accepted != bytes_queued || expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int     start;
		octet_t s0;
		octet_t s1;
		octet_t kind;
		frame.valid     = 1'b0;
		frame.data_byte = '0;
		frame.last_byte = 1'b0;
		verdict.ready   = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = nfc_pkg::REG_SIG_FIRST;
		cfg.data        = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: one frame for each verdict, with byte values at both
		// ends of their range and registers at their extremes.
		program_checker(8'hFF, 8'h00, 8'h80);
		push_byte(8'h00, 1'b1);                                     // single byte
		queue_frame(8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 0, 8'h00);  // good
		queue_frame(8'h00, 8'h00, 8'h80, 8'h00, 8'h01, 0, 8'h00);  // bad signature
		queue_frame(8'hFF, 8'h00, 8'h7F, 8'h00, 8'h34, 0, 8'h00);  // wrong type
		queue_frame(8'hFF, 8'h00, 8'h80, 8'h01, 8'h12, 0, 8'h00);  // length off
		queue_frame(8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 0, 8'hFF);  // bad checksum
		wait_idle();

		// Random part, one register setting per phase. Some phases run with
		// no gaps at all on either side.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					s0 = 8'h00; s1 = 8'h00; kind = 8'h00;
				end
				1: begin
					s0 = 8'hFF; s1 = 8'hFF; kind = 8'hFF;
				end
				default: begin
					s0 = octet_t'($urandom);
					s1 = octet_t'($urandom);
					kind = octet_t'($urandom);
				end
			endcase
			program_checker(s0, s1, kind);
			@(posedge clk);
			idling = (phase % 3 != 2);
			// A frame long enough to saturate the byte count, which must
			// then fail on length.
			if (phase == 3)
				queue_frame(s0, s1, kind, 8'hFF, octet_t'($urandom), 514, 8'h00);
			// The largest frame that can pass.
			if (phase == 5)
				queue_frame(s0, s1, kind, 8'hFF, octet_t'($urandom), 255, 8'h00);
			start = bytes_queued;
			while (bytes_queued - start < RANDOM_BYTES / PHASES)
				queue_random_frame();
			wait_idle();
		end

		if (error_count == 0)
			$display("[notify_frame_checker] OK");
		else
			$display("[notify_frame_checker] ERROR");
		$finish;
	end

endmodule
